[hdl/plm_limited_face_reconstruction_assert.svh]
// Assertion macros for the face reconstruction block and its checker.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef PLM_LIMITED_FACE_RECONSTRUCTION_ASSERT_SVH
`define PLM_LIMITED_FACE_RECONSTRUCTION_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define PLFR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define PLFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/plfr_pkg.sv]
// Shared types and constants of the face reconstruction block.
// No dependencies; imported by every module of the block.
package plfr_pkg;

  localparam int unsigned DATA_W = 32;   // Q16.16 cell and face values
  localparam int unsigned DIFF_W = DATA_W + 1;

  // Limiter selection codes
  typedef enum logic [1:0] {
    LIM_ZERO    = 2'd0,
    LIM_CENTRED = 2'd1,
    LIM_MINMOD  = 2'd2,
    LIM_MC      = 2'd3
  } limiter_e;

  localparam limiter_e LIM_RESET = LIM_MINMOD;

  // Three-cell stencil, a oldest
  typedef struct packed {
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] c;
  } stencil_t;

  // Stage register contents handed to the limiter
  typedef struct packed {
    logic     valid;
    stencil_t st;
  } stage_t;

endpackage

[hdl/plfr_window.sv]
// Cell window (last two values and fill count) plus the stencil stage register.
// Depends on plfr_pkg.
module plfr_window import plfr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [DATA_W-1:0] cell_value_i,
  input  logic              row_start_i,
  input  logic              advance_i,
  output stage_t            stage_o
);

  logic [DATA_W-1:0] prev_q, prev_prev_q;
  logic [1:0]        fill_q, fill_d, fill_eff;
  logic              accept, emit;
  logic              stage_valid_q;
  stencil_t          stage_st_q;
  stage_t            stage_d;

  // Hold an item only while the stage is full and cannot move on
  assign in_stall_o = stage_valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Restart the row count on row start, saturate at two held cells
  always_comb begin
    fill_eff = row_start_i ? 2'd0 : fill_q;
    emit     = (fill_eff == 2'd2);
    fill_d   = emit ? 2'd2 : fill_eff + 2'd1;
  end

  // Load the stage with a full stencil or drain it
  always_comb begin
    stage_d.valid = stage_valid_q;
    stage_d.st    = stage_st_q;
    if (accept) begin
      stage_d.valid = emit;
      stage_d.st.a  = prev_prev_q;
      stage_d.st.b  = prev_q;
      stage_d.st.c  = cell_value_i;
    end else if (advance_i) begin
      stage_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q        <= 2'd0;
      prev_q        <= '0;
      prev_prev_q   <= '0;
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_d.valid;
      if (accept) begin
        fill_q      <= fill_d;
        prev_prev_q <= prev_q;
        prev_q      <= cell_value_i;
      end
    end
  end

  // Stencil payload needs no reset
  always_ff @(posedge clk_i) begin
    stage_st_q <= stage_d.st;
  end

  assign stage_o.valid = stage_valid_q;
  assign stage_o.st    = stage_st_q;

endmodule

[hdl/plfr_limiter.sv]
// Limited slope of the middle cell and the two rounded, saturated face values.
// Depends on plfr_pkg; purely combinational.
module plfr_limiter import plfr_pkg::*; (
  input  stencil_t          st_i,
  input  limiter_e          mode_i,
  output logic [DATA_W-1:0] upper_o,
  output logic [DATA_W-1:0] lower_o
);

  localparam int unsigned S4_W   = DIFF_W + 3;  // four times the slope
  localparam int unsigned FACE_W = DATA_W + 6;  // face in 1/8 LSB units
  localparam int unsigned MIN_W  = DIFF_W + 3;

  logic signed [DATA_W-1:0] a, b, c;
  logic signed [DIFF_W-1:0] dl, dr, dc;
  logic [DIFF_W-1:0]        abs_dl, abs_dr, abs_dc;
  logic                     same;
  logic [MIN_W-1:0]         t_dc, t_dr, t_dl, m_rl, m_all;
  logic signed [S4_W-1:0]   mag, s4;
  logic signed [FACE_W-1:0] b8, up8, lo8, up_r, lo_r;

  // Saturate a rounded face to the signed 32-bit range
  function automatic logic [DATA_W-1:0] sat(input logic signed [FACE_W-1:0] v);
    logic hi_ok;
    hi_ok = (v[FACE_W-1:DATA_W-1] == '0) || (v[FACE_W-1:DATA_W-1] == '1);
    if (hi_ok) begin
      sat = v[DATA_W-1:0];
    end else if (v[FACE_W-1]) begin
      sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  // Exact one-sided and centred differences
  always_comb begin
    a      = st_i.a;
    b      = st_i.b;
    c      = st_i.c;
    dl     = DIFF_W'(b) - DIFF_W'(a);
    dr     = DIFF_W'(c) - DIFF_W'(b);
    dc     = DIFF_W'(c) - DIFF_W'(a);
    abs_dl = dl[DIFF_W-1] ? DIFF_W'(-dl) : DIFF_W'(dl);
    abs_dr = dr[DIFF_W-1] ? DIFF_W'(-dr) : DIFF_W'(dr);
    abs_dc = dc[DIFF_W-1] ? DIFF_W'(-dc) : DIFF_W'(dc);
    same   = (dl != '0) && (dr != '0) && (dl[DIFF_W-1] == dr[DIFF_W-1]);
  end

  // Monotonized-central magnitude: min(2|dc|, 8|dr|, 8|dl|) in quarter units
  always_comb begin
    t_dc  = MIN_W'({abs_dc, 1'b0});
    t_dr  = {abs_dr, 3'b000};
    t_dl  = {abs_dl, 3'b000};
    m_rl  = (t_dr < t_dl) ? t_dr : t_dl;
    m_all = (t_dc < m_rl) ? t_dc : m_rl;
    mag   = $signed(S4_W'(m_all));
  end

  // Select four times the limited slope
  always_comb begin
    case (mode_i)
      LIM_CENTRED: s4 = S4_W'(dc) <<< 1;
      LIM_MINMOD: begin
        if (!same) begin
          s4 = '0;
        end else if (abs_dl < abs_dr) begin
          s4 = S4_W'(dl) <<< 2;
        end else if (abs_dr < abs_dl) begin
          s4 = S4_W'(dr) <<< 2;
        end else begin
          s4 = '0;
        end
      end
      LIM_MC:  s4 = !same ? '0 : (dc[DIFF_W-1] ? -mag : mag);
      default: s4 = '0;
    endcase
  end

  // Round to nearest with ties up (add half, floor), then saturate
  always_comb begin
    b8      = FACE_W'(b) <<< 3;
    up8     = b8 + FACE_W'(s4) + FACE_W'(4);
    lo8     = b8 - FACE_W'(s4) + FACE_W'(4);
    up_r    = up8 >>> 3;
    lo_r    = lo8 >>> 3;
    upper_o = sat(up_r);
    lower_o = sat(lo_r);
  end

endmodule

[hdl/plm_limited_face_reconstruction.sv]
// Piecewise-linear face reconstruction with a selectable slope limiter.
// Takes one signed Q16.16 cell value per item and, once a row holds three
// cells, gives the middle cell's upper and lower face values. Rate: one item
// per cycle while the input is not stalled; an item that completes a stencil
// is loaded into the stencil stage register when accepted and its result into
// the output register once that register is free or being drained, with the
// limiter and rounding logic between them. With the output stalled the block
// holds two results and then stalls its input. The first two items of a row
// (and after reset) give no result. Write limiter_mode only while idle.
// Depends on plfr_pkg, plfr_window and plfr_limiter.
module plm_limited_face_reconstruction import plfr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // item in
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [DATA_W-1:0] cell_value_i,
  input  logic              row_start_i,
  // result out
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DATA_W-1:0] upper_face_value_o,
  output logic [DATA_W-1:0] lower_face_value_o,
  // limiter mode register
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_data_i
);

  limiter_e          mode_q;
  stage_t            stage;
  logic              advance;
  logic              out_valid_q;
  logic [DATA_W-1:0] upper_q, lower_q, upper_d, lower_d;

  // Mode register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= LIM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= limiter_e'(cfg_data_i);
    end
  end

  // Output register free or being drained
  assign advance = !out_valid_q || !out_stall_i;

  plfr_window u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cell_value_i (cell_value_i),
    .row_start_i  (row_start_i),
    .advance_i    (advance),
    .stage_o      (stage)
  );

  plfr_limiter u_limiter (
    .st_i    (stage.st),
    .mode_i  (mode_q),
    .upper_o (upper_d),
    .lower_o (lower_d)
  );

  // Result register: load on advance, hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= stage.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && stage.valid) begin
      upper_q <= upper_d;
      lower_q <= lower_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign upper_face_value_o = upper_q;
  assign lower_face_value_o = lower_q;

endmodule

[hdl/plfr_checker.sv]
// Port-level checks of the face reconstruction block, bound to its top level.
// Depends on plm_limited_face_reconstruction_assert.svh and plfr_pkg.
`include "plm_limited_face_reconstruction_assert.svh"

module plfr_checker import plfr_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              row_start_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [DATA_W-1:0] upper_face_value_o,
  input logic [DATA_W-1:0] lower_face_value_o
);

  logic                in_take;
  logic [2*DATA_W-1:0] faces;

  // Item taken that may complete a stencil
  assign in_take = in_valid_i && !in_stall_o && !row_start_i;
  assign faces   = {upper_face_value_o, lower_face_value_o};

  // Input backs up only behind a stalled, full output
  `PLFR_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // A new result comes from an accepted item by way of the stencil stage register, never a row start
  `PLFR_ASSERT_IMPL(a_result_source, clk_i, rst_ni, $rose(out_valid_o), $past(in_take, 2))

  // Stalled result stays valid
  `PLFR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // Stalled result keeps its faces
  `PLFR_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(faces))

endmodule

bind plm_limited_face_reconstruction plfr_checker u_plfr_checker (.*);
